FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held (active low reset)
`define SMSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define SMSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/smsp_pkg.sv
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared constants and controller/datapath interface types of the slot move
// step planner.
// ----------------------------------------------------------------------------
package smsp_pkg;

  // Default number of slots served by the carriage
  localparam int SLOT_COUNT_DEF = 16;

  // Fixed field widths
  localparam int SLOT_W  = 5;
  localparam int INDEX_W = 4;
  localparam int GAP_W   = 16;
  localparam int STEP_W  = 21;

  // Largest step magnitude before the sign is applied
  localparam int unsigned MAG_MAX = 32'd1048575;

  // Reset value of the compensation register
  localparam logic [GAP_W-1:0] COMP_RESET = 16'd50;

  // Request kinds carried in the action field
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_MOVE  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr;        // write gap entry from request fields
    logic load;      // latch move request, set up the walk
    logic rd;        // issue one gap read, advance index
    logic emit_nop;  // emit a no-move result
    logic fin;       // finish move: compensate, saturate, emit, update
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_ok;      // requested slot is valid and differs from current
    logic issue_last;  // current read index is the last gap of the move
  } dp_status_t;

endpackage

FILE: rtl/core/smsp_ram.sv
// ----------------------------------------------------------------------------
// smsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/smsp_ctrl.sv
// ----------------------------------------------------------------------------
// smsp_ctrl
// Sequencer for the step planner: takes requests, walks the gap reads of a
// move and tells the datapath when to finish or emit a no-move result.
// ----------------------------------------------------------------------------
module smsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_action,
  input  smsp_pkg::dp_status_t status,
  output smsp_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOP,
    S_RUN,
    S_TAIL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == smsp_pkg::ACT_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = status.req_ok ? S_RUN : S_NOP;
          end
        end
      end
      S_NOP: begin
        cmd.emit_nop = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RUN: begin
        cmd.rd = 1'b1;
        if (status.issue_last) begin
          state_nxt = S_TAIL;
        end
      end
      // last read data lands in the accumulator
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: rtl/core/smsp_dp.sv
// ----------------------------------------------------------------------------
// smsp_dp
// Datapath of the step planner: gap table, walk index, accumulator,
// compensation, saturation, carriage state and result registers.
// ----------------------------------------------------------------------------
module smsp_dp #(
  parameter int SLOT_COUNT = smsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smsp_pkg::dp_cmd_t                    cmd,
  output smsp_pkg::dp_status_t                 status,
  input  logic                                 cfg_we,
  input  logic [smsp_pkg::GAP_W-1:0]           cfg_wdata,
  input  logic [smsp_pkg::SLOT_W-1:0]          in_target_slot,
  input  logic [smsp_pkg::INDEX_W-1:0]         in_entry_index,
  input  logic [smsp_pkg::GAP_W-1:0]           in_entry_steps,
  output logic                                 out_strobe,
  output logic signed [smsp_pkg::STEP_W-1:0]   out_step_count,
  output logic                                 out_moved,
  output logic [smsp_pkg::SLOT_W-1:0]          out_current_slot
);

  localparam int SLOT_W    = smsp_pkg::SLOT_W;
  localparam int GAP_W     = smsp_pkg::GAP_W;
  localparam int STEP_W    = smsp_pkg::STEP_W;
  localparam int GAP_DEPTH = SLOT_COUNT - 1;
  localparam int AW        = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
  localparam int IDX_W     = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int SUM_W     = $clog2(SLOT_COUNT) + GAP_W;
  localparam int ACC_W     = (SUM_W > STEP_W) ? SUM_W : STEP_W;

  logic [GAP_W-1:0]  comp_r;
  logic [SLOT_W-1:0] slot_now_r;
  logic              travel_up_r;
  logic [SLOT_W-1:0] tgt_r;
  logic              dir_up_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  last_r;
  logic              rd_vld_r;
  logic [ACC_W-1:0]  acc_r;

  logic                     out_strobe_r;
  logic signed [STEP_W-1:0] out_step_r;
  logic                     out_moved_r;
  logic [SLOT_W-1:0]        out_slot_r;

  logic              up_req;
  logic [SLOT_W-1:0] lo_slot;
  logic [SLOT_W-1:0] hi_slot;
  logic              wr_ok;
  logic [GAP_W-1:0]  rd_data;
  logic [ACC_W-1:0]  mag_sum;
  logic [ACC_W-1:0]  mag_sat;
  logic [STEP_W-1:0] mag_step;

  // request decode against the current slot
  assign up_req  = in_target_slot > slot_now_r;
  assign lo_slot = up_req ? slot_now_r : in_target_slot;
  assign hi_slot = up_req ? in_target_slot : slot_now_r;

  assign status.req_ok = (in_target_slot != '0) &&
                         (32'(in_target_slot) <= SLOT_COUNT) &&
                         (in_target_slot != slot_now_r);
  assign status.issue_last = (idx_r == last_r);

  // writes beyond the table are dropped
  assign wr_ok = cmd.wr && (32'(in_entry_index) < GAP_DEPTH);

  smsp_ram #(
    .WIDTH(GAP_W),
    .DEPTH(GAP_DEPTH)
  ) u_gap_ram (
    .clk    (clk),
    .wr_en  (wr_ok),
    .wr_addr(AW'(in_entry_index)),
    .wr_data(in_entry_steps),
    .rd_en  (cmd.rd),
    .rd_addr(idx_r[AW-1:0]),
    .rd_data(rd_data)
  );

  // compensation on reversal, then clamp the magnitude
  assign mag_sum  = acc_r + ((dir_up_r != travel_up_r) ? ACC_W'(comp_r) : '0);
  assign mag_sat  = (mag_sum > ACC_W'(smsp_pkg::MAG_MAX)) ?
                    ACC_W'(smsp_pkg::MAG_MAX) : mag_sum;
  assign mag_step = mag_sat[STEP_W-1:0];

  // compensation register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r <= smsp_pkg::COMP_RESET;
    end else if (cfg_we) begin
      comp_r <= cfg_wdata;
    end
  end

  // move setup, gap walk and accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
    end
    if (cmd.load) begin
      tgt_r    <= in_target_slot;
      dir_up_r <= up_req;
      idx_r    <= IDX_W'(lo_slot) - IDX_W'(1);
      last_r   <= IDX_W'(hi_slot) - IDX_W'(2);
      acc_r    <= '0;
    end else begin
      if (cmd.rd) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (rd_vld_r) begin
        acc_r <= acc_r + ACC_W'(rd_data);
      end
    end
  end

  // carriage state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_now_r  <= SLOT_W'(1);
      travel_up_r <= 1'b1;
    end else if (cmd.fin) begin
      slot_now_r  <= tgt_r;
      travel_up_r <= dir_up_r;
    end
  end

  // result registers, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.fin || cmd.emit_nop;
    end
    if (cmd.fin) begin
      out_step_r  <= dir_up_r ? -$signed(mag_step) : $signed(mag_step);
      out_moved_r <= 1'b1;
      out_slot_r  <= tgt_r;
    end else if (cmd.emit_nop) begin
      out_step_r  <= '0;
      out_moved_r <= 1'b0;
      out_slot_r  <= slot_now_r;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_step_count   = out_step_r;
  assign out_moved        = out_moved_r;
  assign out_current_slot = out_slot_r;

endmodule

FILE: rtl/core/slot_move_step_planner_core.sv
// ----------------------------------------------------------------------------
// slot_move_step_planner_core
// Stepper move planner for a carriage serving numbered slots, with a loadable
// gap table and backlash compensation on direction reversal.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A table write
// (in_action = 0) gives no result and does not raise busy. A move request to
// the current slot or to a slot out of range gives a no-move result through
// state S_NOP and the result registers. A real move over n gaps (n = distance
// in slots) reads the gap table one entry per cycle through its single read
// port, then passes S_TAIL, S_FIN and the result registers; the next request
// may be taken in the cycle the result is shown. Each result is on the out_
// ports for one cycle only, marked by out_strobe, and cannot be held off: the
// receiver must take it in that cycle. step_count is negative toward higher
// slots. Write cfg_wdata only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slot_move_step_planner_core #(
  parameter int SLOT_COUNT = smsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_action,
  input  logic [smsp_pkg::SLOT_W-1:0]          in_target_slot,
  input  logic [smsp_pkg::INDEX_W-1:0]         in_entry_index,
  input  logic [smsp_pkg::GAP_W-1:0]           in_entry_steps,
  output logic                                 out_strobe,
  output logic signed [smsp_pkg::STEP_W-1:0]   out_step_count,
  output logic                                 out_moved,
  output logic [smsp_pkg::SLOT_W-1:0]          out_current_slot,
  input  logic                                 cfg_we,
  input  logic [smsp_pkg::GAP_W-1:0]           cfg_wdata
);

  smsp_pkg::dp_cmd_t    cmd;
  smsp_pkg::dp_status_t status;

  // sequencer
  smsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_action(in_action),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath
  smsp_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_target_slot  (in_target_slot),
    .in_entry_index  (in_entry_index),
    .in_entry_steps  (in_entry_steps),
    .out_strobe      (out_strobe),
    .out_step_count  (out_step_count),
    .out_moved       (out_moved),
    .out_current_slot(out_current_slot)
  );

  // a result only follows a request that held the block busy
  `SMSP_ASSERT(a_strobe_after_busy, clk, rst_n, out_strobe |-> $past(busy), "result without request")
  // the block is free again when a result is shown
  `SMSP_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy, "result while still busy")
  // a no-move result carries zero steps
  `SMSP_ASSERT(a_nomove_zero, clk, rst_n, (out_strobe && !out_moved) |-> (out_step_count == '0), "no-move result with steps")
  // a table write never occupies the block
  `SMSP_ASSERT(a_write_single, clk, rst_n, (start && !busy && (in_action == smsp_pkg::ACT_WRITE)) |=> !busy, "table write held busy")

endmodule
